/* hdl/rgb332_conv3x3_macros.svh */
`ifndef RGB332_CONV3X3_MACROS_SVH
`define RGB332_CONV3X3_MACROS_SVH

// Checks sampled on clk, off while arst_n is low.
`define R3C_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`define R3C_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* hdl/r3c_pkg.sv */
`timescale 1ns / 1ps

package r3c_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IW_W       = 7;
	localparam int DIV_W      = 8;
	localparam int SUM_W      = 14;
	localparam int REM_W      = 13;
	localparam int CH_W       = 3;

	localparam logic [PIX_W-1:0] RED_MASK   = 8'b11100000;
	localparam logic [PIX_W-1:0] GREEN_MASK = 8'b00011100;
	localparam logic [PIX_W-1:0] BLUE_MASK  = 8'b00000011;
	localparam logic [CH_W-1:0]  RG_MAX     = 3'b111;
	localparam logic [CH_W-1:0]  B_MAX      = 3'b011;

	localparam logic [IW_W-1:0]       RST_IMAGE_WIDTH = 7'd64;
	localparam logic [CFG_DATA_W-1:0] RST_KERNEL_TOP  = 24'd0;
	localparam logic [CFG_DATA_W-1:0] RST_KERNEL_MID  = 24'd256;
	localparam logic [CFG_DATA_W-1:0] RST_KERNEL_BOT  = 24'd0;
	localparam logic [DIV_W-1:0]      RST_DIVISOR     = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_KERNEL_TOP    = 3'd1,
		REG_KERNEL_MID    = 3'd2,
		REG_KERNEL_BOTTOM = 3'd3,
		REG_DIVISOR       = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_BUSY
	} state_t;

	typedef logic [PIX_W-1:0] pix_t;
	// [row][column], row 0 is the oldest line, column 2 the newest pixel
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;
	// [kernel row], coefficient c in bits 8c+7:8c
	typedef logic [2:0][CFG_DATA_W-1:0] kern_t;

	typedef struct packed {
		logic start;
		logic top_off;
		logic bot_off;
		logic left_off;
		logic right_off;
		logic last;
	} job_t;

	// channel 0 red, 1 green, 2 blue; two's complement
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic [2:0][SUM_W-1:0] sum;
	} sum_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		pix_t       pixel;
	} res_t;

	function automatic logic [CH_W-1:0] red_of(input pix_t p);
		pix_t t;
		t = p & RED_MASK;
		return t[7:5];
	endfunction

	function automatic logic [CH_W-1:0] green_of(input pix_t p);
		pix_t t;
		t = p & GREEN_MASK;
		return t[4:2];
	endfunction

	function automatic logic [CH_W-1:0] blue_of(input pix_t p);
		pix_t t;
		t = p & BLUE_MASK;
		return {1'b0, t[1:0]};
	endfunction

endpackage

/* hdl/r3c_ram.sv */
`timescale 1ns / 1ps

module r3c_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/r3c_seq.sv */
`timescale 1ns / 1ps

module r3c_seq #(
	parameter int MAX_WIDTH = 64,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 2),
	localparam int EW = (WW > r3c_pkg::IW_W) ? WW : r3c_pkg::IW_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  r3c_pkg::pix_t               s_tdata,
	input  logic                        s_tuser,
	input  logic [r3c_pkg::IW_W-1:0]    image_width,
	input  logic                        width_wr,
	input  logic                        take,
	output logic                        ram_re,
	output logic                        ram_we,
	output logic [AW-1:0]               ram_addr,
	output logic [2*r3c_pkg::PIX_W-1:0] ram_wdata,
	input  logic [2*r3c_pkg::PIX_W-1:0] ram_rdata,
	output r3c_pkg::win_t               win,
	output r3c_pkg::job_t               job
);

	r3c_pkg::state_t state_q, state_n;
	logic [AW-1:0]   col_q;
	logic [WW-1:0]   row_q;
	r3c_pkg::pix_t   pix_q;
	r3c_pkg::win_t   win_q;
	r3c_pkg::job_t   job_q;

	logic [EW-1:0]   iw_x;
	logic [EW-1:0]   w_x;
	logic [WW-1:0]   w;
	logic [WW-1:0]   col_x;
	logic [WW-1:0]   col_inc;
	logic [WW-1:0]   cr;
	logic [WW-1:0]   cc;
	logic            ctr_valid;
	r3c_pkg::pix_t   up;
	r3c_pkg::pix_t   mid;

	// effective side length, saturated to 3..MAX_WIDTH
	always_comb begin
		iw_x = EW'(image_width);
		if (iw_x < EW'(3)) begin
			w_x = EW'(3);
		end else if (iw_x > EW'(MAX_WIDTH)) begin
			w_x = EW'(MAX_WIDTH);
		end else begin
			w_x = iw_x;
		end
		w = w_x[WW-1:0];
	end

	// centre of the window sits one row and one column behind the input
	always_comb begin
		col_x = WW'(col_q);
		col_inc = col_x + WW'(1);
		if (col_q != '0) begin
			ctr_valid = (row_q != '0);
			cr = row_q - WW'(1);
			cc = col_x - WW'(1);
		end else begin
			ctr_valid = (row_q >= WW'(2));
			cr = row_q - WW'(2);
			cc = w - WW'(1);
		end
		ctr_valid = ctr_valid && (cr < w);
	end

	assign up  = ram_rdata[2*r3c_pkg::PIX_W-1:r3c_pkg::PIX_W];
	assign mid = ram_rdata[r3c_pkg::PIX_W-1:0];

	always_comb begin
		state_n = state_q;
		case (state_q)
			r3c_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_n = r3c_pkg::ST_READ;
				end
			end
			r3c_pkg::ST_READ: begin
				state_n = ctr_valid ? r3c_pkg::ST_BUSY : r3c_pkg::ST_IDLE;
			end
			r3c_pkg::ST_BUSY: begin
				if (take) begin
					state_n = r3c_pkg::ST_IDLE;
				end
			end
			default: state_n = r3c_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == r3c_pkg::ST_IDLE);
		ram_re    = s_tready && s_tvalid;
		ram_we    = (state_q == r3c_pkg::ST_READ);
		ram_addr  = col_q;
		// upper takes the old middle line, middle takes the new pixel
		ram_wdata = {mid, pix_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r3c_pkg::ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			win_q   <= '0;
			job_q   <= '0;
		end else begin
			state_q     <= state_n;
			job_q.start <= (state_q == r3c_pkg::ST_READ) && ctr_valid;
			if (width_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (state_q == r3c_pkg::ST_READ) begin
				if (row_q >= w + WW'(1)) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= w) begin
					col_q <= '0;
					row_q <= row_q + WW'(1);
				end else begin
					col_q <= col_inc[AW-1:0];
				end
			end
			if (state_q == r3c_pkg::ST_READ) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2]     <= up;
				win_q[1][2]     <= mid;
				win_q[2][2]     <= pix_q;
				job_q.top_off   <= (cr == '0);
				job_q.bot_off   <= (cr == w - WW'(1));
				job_q.left_off  <= (cc == '0);
				job_q.right_off <= (cc == w - WW'(1));
				job_q.last      <= (cr == w - WW'(1)) && (cc == w - WW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pix_q <= s_tuser ? '0 : s_tdata;
		end
	end

	assign win = win_q;
	assign job = job_q;

endmodule

/* hdl/r3c_mac.sv */
`timescale 1ns / 1ps

module r3c_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  r3c_pkg::job_t  job,
	input  r3c_pkg::win_t  win,
	input  r3c_pkg::kern_t kern,
	output r3c_pkg::sum_t  sum
);

	logic                           busy_q;
	logic [1:0]                     k_q;
	logic                           done_q;
	logic [2:0][r3c_pkg::SUM_W-1:0] acc_q;
	logic [2:0][r3c_pkg::SUM_W-1:0] acc_n;

	// one window row (kernel row 2-k) per cycle, three taps per channel
	always_comb begin
		logic [r3c_pkg::CFG_DATA_W-1:0] krow;
		r3c_pkg::pix_t                  px;
		logic                           off;
		logic [7:0]                     c8;
		logic [2:0][r3c_pkg::CH_W-1:0]  ch;
		logic signed [11:0]             pr;
		acc_n = acc_q;
		krow = kern[2'd2 - k_q];
		for (int j = 0; j < 3; j++) begin
			px = win[k_q][j];
			off = ((k_q == 2'd0) && job.top_off) || ((k_q == 2'd2) && job.bot_off) ||
				((j == 0) && job.left_off) || ((j == 2) && job.right_off);
			if (off) begin
				px = '0;
			end
			c8 = krow[8*(2-j) +: 8];
			ch[0] = r3c_pkg::red_of(px);
			ch[1] = r3c_pkg::green_of(px);
			ch[2] = r3c_pkg::blue_of(px);
			for (int c = 0; c < 3; c++) begin
				pr = $signed({9'b0, ch[c]}) * $signed({{4{c8[7]}}, c8});
				acc_n[c] = acc_n[c] + {{2{pr[11]}}, pr};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (k_q == 2'd2);
			if (job.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_n;
		end
	end

	assign sum.valid = done_q;
	assign sum.last  = job.last;
	assign sum.sum   = acc_q;

endmodule

/* hdl/r3c_div.sv */
`timescale 1ns / 1ps

module r3c_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  r3c_pkg::sum_t             sum,
	input  logic [r3c_pkg::DIV_W-1:0] divisor,
	input  logic                      take,
	output r3c_pkg::res_t             res
);

	logic                           busy_q;
	logic [1:0]                     step_q;
	logic                           done_q;
	logic                           last_q;
	logic [2:0][r3c_pkg::REM_W-1:0] rem_q;
	logic [2:0][r3c_pkg::CH_W-1:0]  quo_q;
	logic [2:0]                     sat_q;

	logic [r3c_pkg::DIV_W-1:0]      d;
	logic [1:0]                     shamt;
	logic [r3c_pkg::REM_W-1:0]      dv;
	logic [2:0]                     ge;
	logic [2:0][r3c_pkg::CH_W-1:0]  val;

	assign d     = (divisor == '0) ? r3c_pkg::DIV_W'(1) : divisor;
	// first step tests for a quotient of 8 or more, then bits 2, 1, 0
	assign shamt = 2'd3 - step_q;
	assign dv    = r3c_pkg::REM_W'(d) << shamt;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ge[c]  = (rem_q[c] >= dv);
			val[c] = sat_q[c] ? r3c_pkg::RG_MAX : quo_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (sum.valid) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum.valid) begin
			last_q <= sum.last;
			for (int c = 0; c < 3; c++) begin
				// negative sums truncate to zero or below and clamp to zero
				rem_q[c] <= sum.sum[c][r3c_pkg::SUM_W-1] ? '0 : sum.sum[c][r3c_pkg::REM_W-1:0];
				quo_q[c] <= '0;
				sat_q[c] <= 1'b0;
			end
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				if (step_q == 2'd0) begin
					sat_q[c] <= ge[c];
				end else if (!sat_q[c] && ge[c]) begin
					rem_q[c]        <= rem_q[c] - dv;
					quo_q[c][shamt] <= 1'b1;
				end
			end
		end
	end

	assign res.valid = done_q;
	assign res.last  = last_q;
	assign res.pixel = {val[0], val[1],
		(val[2] > r3c_pkg::B_MAX) ? r3c_pkg::B_MAX[1:0] : val[2][1:0]};

endmodule

/* hdl/rgb332_conv3x3.sv */
`timescale 1ns / 1ps

// 3x3 convolution of a square RGB332 raster stream. Pixels enter in raster
// order; each channel of the pixel one row and one column behind the input is
// convolved with the kernel rotated by 180 degrees, divided by the divisor
// (truncating, 0 acts as 1) and clamped to 0..7 (red, green) or 0..3 (blue).
// Neighbors outside the image count as zero. After the W*W pixels of a frame
// send W+1 items with tuser set to flush the last results; the next item
// starts a new frame. Writing image_width restarts the frame. Items are taken
// one at a time: an item that completes no output pixel passes only through a
// line-store read and write-back; one that does also passes through three
// kernel-row multiply-accumulate passes, four compare-subtract divide steps
// and the hand-off to the output register, which waits while that register
// stays full. The block accepts the next item while a result waits in the
// output register.
module rgb332_conv3x3 #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // pixel_in[7:0]
	input  logic                            s_tuser,   // is_padding
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // pixel_out[7:0]
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [r3c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [r3c_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int LW = 2 * r3c_pkg::PIX_W;

	logic [r3c_pkg::IW_W-1:0]       image_width_q;
	r3c_pkg::kern_t                 kern_q;
	logic [r3c_pkg::DIV_W-1:0]      divisor_q;
	logic                           width_wr;
	logic                           cfg_req;

	logic                           ram_re;
	logic                           ram_we;
	logic [AW-1:0]                  ram_addr;
	logic [LW-1:0]                  ram_wdata;
	logic [LW-1:0]                  ram_rdata;
	r3c_pkg::win_t                  win;
	r3c_pkg::job_t                  job;
	r3c_pkg::sum_t                  sum;
	r3c_pkg::res_t                  res;
	logic                           take;

	logic                           m_tvalid_q;
	r3c_pkg::pix_t                  pixel_q;
	logic                           last_q;

	assign cfg_ready = 1'b1;
	assign cfg_req   = cfg_valid && cfg_ready;
	assign width_wr  = cfg_req &&
		(r3c_pkg::reg_idx_t'(cfg_index) == r3c_pkg::REG_IMAGE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= r3c_pkg::RST_IMAGE_WIDTH;
			kern_q[0]     <= r3c_pkg::RST_KERNEL_TOP;
			kern_q[1]     <= r3c_pkg::RST_KERNEL_MID;
			kern_q[2]     <= r3c_pkg::RST_KERNEL_BOT;
			divisor_q     <= r3c_pkg::RST_DIVISOR;
		end else if (cfg_req) begin
			case (r3c_pkg::reg_idx_t'(cfg_index))
				r3c_pkg::REG_IMAGE_WIDTH:   image_width_q <= cfg_data[r3c_pkg::IW_W-1:0];
				r3c_pkg::REG_KERNEL_TOP:    kern_q[0]     <= cfg_data;
				r3c_pkg::REG_KERNEL_MID:    kern_q[1]     <= cfg_data;
				r3c_pkg::REG_KERNEL_BOTTOM: kern_q[2]     <= cfg_data;
				r3c_pkg::REG_DIVISOR:       divisor_q     <= cfg_data[r3c_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// both line stores share one word: upper line high byte, middle line low
	r3c_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	r3c_seq #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.image_width (image_width_q),
		.width_wr    (width_wr),
		.take        (take),
		.ram_re      (ram_re),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.win         (win),
		.job         (job)
	);

	r3c_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.win    (win),
		.kern   (kern_q),
		.sum    (sum)
	);

	r3c_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.sum     (sum),
		.divisor (divisor_q),
		.take    (take),
		.res     (res)
	);

	assign take = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_q <= res.pixel;
			last_q  <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pixel_q;
	assign m_tlast  = last_q;

endmodule

/* hdl/r3c_chk.sv */
`timescale 1ns / 1ps

`include "rgb332_conv3x3_macros.svh"

module r3c_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	`R3C_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output request dropped")
	`R3C_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled output changed")
	// one item in flight: the cycle after an accept is never ready
	`R3C_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")
	// a new result only appears at the end of a busy item
	`R3C_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready), "result without work")

endmodule

bind rgb332_conv3x3 r3c_chk u_r3c_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
